// ===== hdl/rctm_pkg.sv =====
// shared constants for the rns ciphertext tensor mulmod unit
// no dependencies
package rctm_pkg;

  localparam int unsigned FieldW     = 31;
  localparam int unsigned LimbIdxW   = 2;
  localparam int unsigned NumModRegs = 4;
  localparam int unsigned ModRegIdxW = 2;
  localparam logic [FieldW-1:0] ModReset = 31'h7FFF_FFFF;

  // s_axis tdata layout
  localparam int unsigned InLimbLo = 0;
  localparam int unsigned InA0Lo   = InLimbLo + LimbIdxW;
  localparam int unsigned InA1Lo   = InA0Lo + FieldW;
  localparam int unsigned InB0Lo   = InA1Lo + FieldW;
  localparam int unsigned InB1Lo   = InB0Lo + FieldW;
  localparam int unsigned InBits   = InB1Lo + FieldW;
  localparam int unsigned InDataW  = ((InBits + 7) / 8) * 8;

  // m_axis tdata layout
  localparam int unsigned OutBits  = 3 * FieldW;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

endpackage

// ===== hdl/rctm_mul.sv =====
// front end: input register, four coefficient products, cross-product sum
// depends on nothing
module rctm_mul #(
  parameter int unsigned CB = 31
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [CB-1:0]              q_i,
  input  logic [CB-1:0]              a0_i,
  input  logic [CB-1:0]              a1_i,
  input  logic [CB-1:0]              b0_i,
  input  logic [CB-1:0]              b1_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [CB-1:0]              q_o,
  output logic [2:0][2*CB:0]         dvd_o
);
  localparam int unsigned PW = 2 * CB;
  localparam int unsigned SW = 2 * CB + 1;

  logic            va_q, vb_q, vc_q;
  logic            en_a, en_b, en_c;
  logic [CB-1:0]   qa_q, a0_q, a1_q, b0_q, b1_q;
  logic [CB-1:0]   qb_q;
  logic [PW-1:0]   p0_q, p01_q, p10_q, p2_q;
  logic [CB-1:0]   qc_q;
  logic [2:0][SW-1:0] dvd_q;

  assign en_c    = !vc_q || ready_i;
  assign en_b    = !vb_q || en_c;
  assign en_a    = !va_q || en_b;
  assign ready_o = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_a) va_q <= valid_i;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      qa_q <= q_i;
      a0_q <= a0_i;
      a1_q <= a1_i;
      b0_q <= b0_i;
      b1_q <= b1_i;
    end
    if (en_b) begin
      qb_q  <= qa_q;
      p0_q  <= PW'(a0_q) * PW'(b0_q);
      p01_q <= PW'(a0_q) * PW'(b1_q);
      p10_q <= PW'(a1_q) * PW'(b0_q);
      p2_q  <= PW'(a1_q) * PW'(b1_q);
    end
    if (en_c) begin
      qc_q     <= qb_q;
      dvd_q[0] <= SW'(p0_q);
      dvd_q[1] <= SW'(p01_q) + SW'(p10_q);
      dvd_q[2] <= SW'(p2_q);
    end
  end

  assign valid_o = vc_q;
  assign q_o     = qc_q;
  assign dvd_o   = dvd_q;
endmodule

// ===== hdl/rctm_mod_cell.sv =====
// one restoring-reduction cell: takes the next dividend bit of three lanes
// depends on nothing
module rctm_mod_cell #(
  parameter int unsigned CB = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [CB-1:0]        q_i,
  input  logic [2:0][CB-1:0]   rem_i,
  input  logic [2:0][2*CB:0]   dvd_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [CB-1:0]        q_o,
  output logic [2:0][CB-1:0]   rem_o,
  output logic [2:0][2*CB:0]   dvd_o
);
  localparam int unsigned SW = 2 * CB + 1;

  logic                v_q, en;
  logic [CB-1:0]       q_q;
  logic [2:0][CB-1:0]  rem_q, rem_d;
  logic [2:0][SW-1:0]  dvd_q, dvd_d;
  logic [2:0][CB:0]    t;

  assign en      = !v_q || ready_i;
  assign ready_o = en;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      t[l]     = {rem_i[l], dvd_i[l][SW-1]};
      rem_d[l] = (t[l] >= (CB+1)'(q_i)) ? CB'(t[l] - (CB+1)'(q_i)) : CB'(t[l]);
      dvd_d[l] = {dvd_i[l][SW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_q   <= q_i;
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  assign valid_o = v_q;
  assign q_o     = q_q;
  assign rem_o   = rem_q;
  assign dvd_o   = dvd_q;
endmodule

// ===== hdl/rns_ciphertext_tensor_mulmod_unit.sv =====
// rns ciphertext tensor product: three modular coefficient products per item
// one item per cycle unless m_axis_tready back-pressure stalls the pipeline
// three front stages form the products, then a chain of reduction cells
// takes one dividend bit each; every stage holds its own handshake
// reset: all stage valids clear, moduli return to 2^31-1
// depends on rctm_pkg, rctm_mul, rctm_mod_cell
module rns_ciphertext_tensor_mulmod_unit #(
  parameter int unsigned LIMBS      = 4,
  parameter int unsigned COEFF_BITS = 31
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rctm_pkg::ModRegIdxW-1:0]     cfg_idx_i,
  input  logic [rctm_pkg::FieldW-1:0]         cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // limb_index, first_c0, first_c1, second_c0, second_c1, zero pad
  input  logic [rctm_pkg::InDataW-1:0]        s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // prod_c0, prod_c1, prod_c2, zero pad
  output logic [rctm_pkg::OutDataW-1:0]       m_axis_tdata
);
  localparam int unsigned CB     = COEFF_BITS;
  localparam int unsigned SW     = 2 * CB + 1;
  localparam int unsigned NCELLS = SW;
  localparam int unsigned FW     = rctm_pkg::FieldW;

  logic [rctm_pkg::NumModRegs-1:0][CB-1:0] mod_q;
  logic [rctm_pkg::LimbIdxW-1:0] limb;
  logic [CB-1:0] q_sel, q_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < rctm_pkg::NumModRegs; k++) mod_q[k] <= CB'(rctm_pkg::ModReset);
    end else if (cfg_we_i) begin
      mod_q[cfg_idx_i] <= cfg_data_i[CB-1:0];
    end
  end

  // bad limb or modulus below two: reduce by one so every lane ends at zero
  always_comb begin
    limb  = s_axis_tdata[rctm_pkg::InLimbLo +: rctm_pkg::LimbIdxW];
    q_sel = mod_q[limb];
    if (32'(limb) >= LIMBS || q_sel < CB'(2)) q_eff = CB'(1);
    else q_eff = q_sel;
  end

  logic [NCELLS:0]                v;
  logic [NCELLS:0]                rdy;
  logic [NCELLS:0][CB-1:0]        q;
  logic [NCELLS:0][2:0][CB-1:0]   rem;
  logic [NCELLS:0][2:0][SW-1:0]   dvd;

  rctm_mul #(.CB(CB)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .q_i     (q_eff),
    .a0_i    (s_axis_tdata[rctm_pkg::InA0Lo +: CB]),
    .a1_i    (s_axis_tdata[rctm_pkg::InA1Lo +: CB]),
    .b0_i    (s_axis_tdata[rctm_pkg::InB0Lo +: CB]),
    .b1_i    (s_axis_tdata[rctm_pkg::InB1Lo +: CB]),
    .valid_o (v[0]),
    .ready_i (rdy[0]),
    .q_o     (q[0]),
    .dvd_o   (dvd[0])
  );
  assign rem[0] = '0;

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    rctm_mod_cell #(.CB(CB)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v[k]),
      .ready_o (rdy[k]),
      .q_i     (q[k]),
      .rem_i   (rem[k]),
      .dvd_i   (dvd[k]),
      .valid_o (v[k+1]),
      .ready_i (rdy[k+1]),
      .q_o     (q[k+1]),
      .rem_o   (rem[k+1]),
      .dvd_o   (dvd[k+1])
    );
  end

  assign rdy[NCELLS]   = m_axis_tready;
  assign m_axis_tvalid = v[NCELLS];
  assign m_axis_tdata  = {(rctm_pkg::OutDataW - rctm_pkg::OutBits)'(0),
                          FW'(rem[NCELLS][2]), FW'(rem[NCELLS][1]), FW'(rem[NCELLS][0])};
endmodule
